// ===== design/potq_pkg.sv =====
`default_nettype none

package potq_pkg;

  // Queue geometry.
  localparam int unsigned DEPTH = 32;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Operation codes of an input item.
  typedef enum logic {
    OP_ADD      = 1'b0,
    OP_SCHEDULE = 1'b1
  } op_e;

  // Input item.
  typedef struct packed {
    op_e         op;
    logic [7:0]  task_id;
    logic [7:0]  prio;
    logic [15:0] burst_len;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [7:0]  out_task_id;
    logic [7:0]  out_prio;
    logic [15:0] out_burst;
    logic        last_flag;
    logic        dropped;
  } out_t;

  // One stored task.
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
  } entry_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_EMIT,
    S_DROP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic insert;
    logic emit;
    logic drop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic last_idx;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/potq_datapath.sv =====
`default_nettype none

module potq_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire potq_pkg::in_t   in_data_i,
  input  wire potq_pkg::cmd_t  cmd_i,
  output potq_pkg::sts_t       sts_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output potq_pkg::out_t       out_data_o
);
  import potq_pkg::*;

  entry_t             entry_q [DEPTH];
  entry_t             entry_d [DEPTH];
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  entry_t             new_q;
  logic [DEPTH-1:0]   before_q, before_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [DEPTH-1:0]   upto_mask;
  logic [DEPTH-1:0]   slot_hot;
  logic [DEPTH-1:0]   shift_mask;
  logic               out_load;

  // Per-position insertion flags, evaluated against the incoming task.
  // A set bit means the new task may sit at that position; the lowest one wins.
  always_comb begin
    before_d = '0;
    before_d[0] = (cnt_q == '0) || (in_data_i.prio >= entry_q[0].prio);
    for (int i = 1; i < DEPTH; i++) begin
      before_d[i] = (CNT_W'(i) == cnt_q) ||
                    ((CNT_W'(i) < cnt_q) && (entry_q[i].prio < in_data_i.prio)) ||
                    ((i >= 2) && (CNT_W'(i - 1) < cnt_q) &&
                     (entry_q[i-1].prio == in_data_i.prio));
    end
  end

  // Lowest set flag: the subtract turns it and all bits below it into a mask.
  assign upto_mask  = before_q ^ (before_q - DEPTH'(1));
  assign slot_hot   = upto_mask & before_q;
  assign shift_mask = ~upto_mask;

  // Entry row: the slot takes the new task, positions above it move up by one.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_d[i] = entry_q[i];
    end
    if (cmd_i.insert) begin
      if (slot_hot[0]) begin
        entry_d[0] = new_q;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (slot_hot[i]) begin
          entry_d[i] = new_q;
        end else if (shift_mask[i]) begin
          entry_d[i] = entry_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  // Fill count.
  assign cnt_d = cmd_i.insert ? cnt_q + CNT_W'(1) : cnt_q;

  // Read index for a schedule run.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.capture) begin
      idx_d = '0;
    end else if (cmd_i.emit) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  // Output register: loaded with an emitted entry or with a refused task.
  assign out_load = cmd_i.emit || cmd_i.drop;

  always_comb begin
    out_d = out_q;
    if (cmd_i.emit) begin
      out_d.out_task_id = entry_q[idx_q].id;
      out_d.out_prio    = entry_q[idx_q].prio;
      out_d.out_burst   = entry_q[idx_q].burst;
      out_d.last_flag   = sts_o.last_idx;
      out_d.dropped     = 1'b0;
    end else if (cmd_i.drop) begin
      out_d.out_task_id = new_q.id;
      out_d.out_prio    = new_q.prio;
      out_d.out_burst   = new_q.burst;
      out_d.last_flag   = 1'b1;
      out_d.dropped     = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Captured task and its flags, plus the output payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      new_q.id    <= in_data_i.task_id;
      new_q.prio  <= in_data_i.prio;
      new_q.burst <= in_data_i.burst_len;
      before_q    <= before_d;
    end
    idx_q <= idx_d;
    out_q <= out_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Status toward the controller.
  assign sts_o.full     = (cnt_q == CNT_W'(DEPTH));
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.last_idx = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/potq_ctrl.sv =====
`default_nettype none

module potq_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire potq_pkg::op_e   in_op_i,
  input  wire potq_pkg::sts_t  sts_i,
  output potq_pkg::cmd_t       cmd_o
);
  import potq_pkg::*;

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_ADD) begin
            state_d = sts_i.full ? S_DROP : S_INSERT;
          end else if (!sts_i.empty) begin
            state_d = S_EMIT;
          end
        end
      end
      S_INSERT: begin
        state_d = S_IDLE;
      end
      S_EMIT: begin
        if (sts_i.out_free && sts_i.last_idx) begin
          state_d = S_IDLE;
        end
      end
      S_DROP: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands. Ready is high in idle, so a valid input
  // there is a transfer.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_INSERT: begin
        cmd_o.insert = 1'b1;
      end
      S_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      S_DROP: begin
        cmd_o.drop = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/priority_ordered_task_queue_unit.sv =====
// Priority-ordered task queue with up to 32 entries kept in descending priority.
// Input channel (in_valid_i/in_ready_o/in_data_i): an add item inserts a task;
// a schedule item reads out every stored task, front to back.
// Output channel (out_valid_o/out_ready_i/out_data_o): one transfer per emitted
// task, last_flag set on the final one; an add to a full queue gives a single
// transfer echoing the task with dropped and last_flag set.
// An add registers a per-entry compare vector in its accept cycle; in the
// next cycle the entry row shifts and the new task is written. No result.
// A schedule moves from idle to the emit state, which loads each stored task
// into the output register, one per cycle while the receiver is ready, paced
// by the single output register. An empty schedule finishes in its accept cycle.
// A single item is in flight at a time: in_ready_o is high only while the
// controller is idle, but a result waiting in the output register does not
// hold off the next add.
// When the receiver stalls, the output register holds its payload and the
// readout pauses at the current entry. Reset empties the queue and clears the
// output valid; stored entries are not cleared.
`default_nettype none

module priority_ordered_task_queue_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire potq_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output potq_pkg::out_t       out_data_o
);
  import potq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer for add, readout and drop.
  potq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_op_i    (in_data_i.op),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Entry row, compare flags and output register.
  potq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== design/potq_checker.sv =====
`default_nettype none

module potq_checker (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_ready_o,
  input  wire potq_pkg::in_t   in_data_i,
  input  wire logic            out_valid_o,
  input  wire logic            out_ready_i,
  input  wire potq_pkg::out_t  out_data_o
);
  import potq_pkg::*;

  logic       out_xfer;
  logic [7:0] prev_prio_q;
  logic       prev_last_q;

  assign out_xfer = out_valid_o && out_ready_i;

  // Remember the previous output transfer of the current run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_prio_q <= '0;
      prev_last_q <= 1'b1;
    end else if (out_xfer) begin
      prev_prio_q <= out_data_o.out_prio;
      prev_last_q <= out_data_o.last_flag;
    end
  end

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output payload changed while stalled");

  // A refused task is always the only result of its item.
  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.dropped |-> out_data_o.last_flag)
    else $error("dropped result without last_flag");

  // No new item is taken in the middle of a readout.
  a_no_accept_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_flag |-> !in_ready_o)
    else $error("input ready during a readout");

  // Tasks of one readout come out in non-increasing priority.
  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !prev_last_q |-> !out_data_o.dropped &&
                                 (out_data_o.out_prio <= prev_prio_q))
    else $error("readout out of priority order");

  // The sender keeps a waiting item steady until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input payload changed while stalled");

endmodule

bind priority_ordered_task_queue_unit potq_checker u_potq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import potq_pkg::*;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // Items waiting to be sent, in order; the front one is on the bus while valid.
  in_t task_feed[$];
  // Results the queue owes, oldest first.
  out_t pending_emits[$];
  out_t next_emit;

  // Mirror of the sorted task store.
  entry_t      stored [DEPTH];
  int unsigned stored_count = 0;

  // Percentages of idle input cycles and stalled output cycles.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_count = 0;

  priority_ordered_task_queue_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // Applies one accepted item to the mirror and queues the results it owes.
  task automatic order_task(input in_t item);
    int unsigned slot;
    int unsigned k;
    out_t r;
    r = '0;
    if (item.op == OP_ADD) begin
      if (stored_count >= DEPTH) begin
        // A full queue refuses the task and echoes it back.
        r.out_task_id = item.task_id;
        r.out_prio    = item.prio;
        r.out_burst   = item.burst_len;
        r.last_flag   = 1'b1;
        r.dropped     = 1'b1;
        pending_emits.push_back(r);
      end else begin
        // Find the insertion point under the tie rule.
        slot = stored_count;
        k = 1;
        if (stored_count == 0 || item.prio >= stored[0].prio) begin
          slot = 0;
        end else begin
          while (k < stored_count && slot == stored_count) begin
            if (stored[k].prio == item.prio) begin
              slot = k + 1;
            end else if (stored[k].prio < item.prio) begin
              slot = k;
            end
            k++;
          end
        end
        for (k = stored_count; k > slot; k--) begin
          stored[k] = stored[k - 1];
        end
        stored[slot].id    = item.task_id;
        stored[slot].prio  = item.prio;
        stored[slot].burst = item.burst_len;
        stored_count++;
      end
    end else begin
      // A schedule reads out every task, front to back.
      for (k = 0; k < stored_count; k++) begin
        r.out_task_id = stored[k].id;
        r.out_prio    = stored[k].prio;
        r.out_burst   = stored[k].burst;
        r.last_flag   = (k + 1 == stored_count);
        r.dropped     = 1'b0;
        pending_emits.push_back(r);
      end
    end
  endtask

  // Driver: on each transfer the item is applied to the mirror, then the next
  // one is offered unless this cycle is chosen to stay idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        order_task(in_data_i);
        void'(task_feed.pop_front());
      end
      if (!in_valid_i || in_ready_o) begin
        if (task_feed.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= task_feed[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and pulls ready at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_emits.size() == 0) begin
          flag_mismatch("unexpected result", 32'(out_data_o.out_task_id), 0);
        end else begin
          next_emit = pending_emits.pop_front();
          if (out_data_o.out_task_id != next_emit.out_task_id)
            flag_mismatch("out_task_id", 32'(out_data_o.out_task_id),
                          32'(next_emit.out_task_id));
          if (out_data_o.out_prio != next_emit.out_prio)
            flag_mismatch("out_prio", 32'(out_data_o.out_prio),
                          32'(next_emit.out_prio));
          if (out_data_o.out_burst != next_emit.out_burst)
            flag_mismatch("out_burst", 32'(out_data_o.out_burst),
                          32'(next_emit.out_burst));
          if (out_data_o.last_flag != next_emit.last_flag)
            flag_mismatch("last_flag", 32'(out_data_o.last_flag),
                          32'(next_emit.last_flag));
          if (out_data_o.dropped != next_emit.dropped)
            flag_mismatch("dropped", 32'(out_data_o.dropped),
                          32'(next_emit.dropped));
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic push_item(input op_e op, input logic [7:0] id, input logic [7:0] prio,
                           input logic [15:0] burst);
    in_t item;
    item.op        = op;
    item.task_id   = id;
    item.prio      = prio;
    item.burst_len = burst;
    task_feed.push_back(item);
  endtask

  task automatic wait_drained();
    while (task_feed.size() != 0 || pending_emits.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Random items: mostly adds with clustered priorities so ties are common.
  task automatic run_random(input int unsigned gap, input int unsigned stall,
                            input int unsigned count);
    int unsigned n;
    logic [7:0] prio;
    gap_pct   = gap;
    stall_pct = stall;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        prio = 8'($urandom_range(0, 255));
      end else begin
        prio = 8'($urandom_range(0, 5) * 50);
      end
      push_item(($urandom_range(0, 99) < 65) ? OP_ADD : OP_SCHEDULE,
                8'($urandom_range(0, 255)), prio, 16'($urandom_range(0, 65535)));
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty schedule, field extremes and every tie case.
    push_item(OP_SCHEDULE, 8'hFF, 8'hFF, 16'hFFFF);
    push_item(OP_ADD, 8'd0,   8'd100, 16'h0000);
    push_item(OP_ADD, 8'd255, 8'd100, 16'hFFFF);  // equals front: new front
    push_item(OP_ADD, 8'd1,   8'd50,  16'h1234);  // lowest so far: tail
    push_item(OP_ADD, 8'd2,   8'd255, 16'h8001);  // highest: front
    push_item(OP_ADD, 8'd3,   8'd100, 16'h00FF);  // after the first equal entry
    push_item(OP_ADD, 8'd4,   8'd0,   16'hFF00);  // zero priority: tail
    push_item(OP_ADD, 8'd5,   8'd75,  16'h5555);  // before the first lower entry
    push_item(OP_ADD, 8'd6,   8'd50,  16'hAAAA);  // after the first equal entry
    push_item(OP_SCHEDULE, 8'h00, 8'h00, 16'h0000);
    push_item(OP_ADD, 8'd7,   8'd0,   16'h0001);  // equal to the tail
    push_item(OP_ADD, 8'd8,   8'd254, 16'h7FFF);  // just below the front
    push_item(OP_ADD, 8'd9,   8'd255, 16'h0002);  // equals a 255 front
    push_item(OP_SCHEDULE, 8'hA5, 8'h5A, 16'hC3C3);
    wait_drained();

    // Random part in idling phases; the queue fills early and then drops.
    run_random(0, 0, 125);
    run_random(75, 0, 125);
    run_random(0, 75, 125);
    run_random(24, 24, 125);

    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/potq_pkg.sv
design/potq_datapath.sv
design/potq_ctrl.sv
design/priority_ordered_task_queue_unit.sv
design/potq_checker.sv
test/tb_top.sv
